/* hdl/dtnp_pkg.sv */
package dtnp_pkg;

    localparam int FRAC_DIGITS = 6;
    localparam int MAG_W       = 63;
    localparam int VAL_W       = MAG_W + 1;
    localparam int NUM_DIGITS  = 10;
    localparam int FP_W        = $clog2(FRAC_DIGITS + 2);
    localparam int EXP_W       = $clog2(FRAC_DIGITS + 1);
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [FP_W-1:0]  FP_LIMIT = FP_W'(FRAC_DIGITS + 1);
    localparam logic [EXP_W-1:0] EXP_INT  = EXP_W'(FRAC_DIGITS);

    localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};
    localparam logic [VAL_W-1:0] SAT_POS = {1'b0, MAG_MAX};
    localparam logic [VAL_W-1:0] SAT_NEG = ~SAT_POS + VAL_W'(1);
    localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {MAG_W{1'b0}}};

    typedef enum logic [1:0] {
        OP_INT_DIGIT,
        OP_FRAC_DIGIT,
        OP_EMIT
    } op_kind_t;

    typedef struct packed {
        op_kind_t         op;
        logic [MAG_W-1:0] addend;
        logic             negative;
        logic             line_end;
    } q_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic            negative;
        logic            pending;
        logic [FP_W-1:0] frac_pos;
    } front_status_t;

    // digit times 10^exp, indexed [exp][digit]
    typedef logic [FRAC_DIGITS:0][NUM_DIGITS-1:0][MAG_W-1:0] addend_tab_t;

    function automatic addend_tab_t make_addend_tab();
        addend_tab_t      tab;
        logic [MAG_W-1:0] p;
        p = MAG_W'(1);
        for (int e = 0; e <= FRAC_DIGITS; e++)
        begin
            for (int d = 0; d < NUM_DIGITS; d++)
            begin
                tab[e][d] = MAG_W'(d) * p;
            end
            p = p * MAG_W'(10);
        end
        return tab;
    endfunction

    localparam addend_tab_t ADDEND_TAB = make_addend_tab();

endpackage

/* hdl/dtnp_front.sv */
module dtnp_front
    import dtnp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,
    input  logic [0:0]    s_tuser,
    input  q_status_t     q_status,
    output logic          push,
    output q_entry_t      push_entry,
    output front_status_t status
);

    logic            negative_reg, negative_next;
    logic            pending_reg, pending_next;
    logic [FP_W-1:0] frac_pos_reg, frac_pos_next;

    logic             accept;
    logic             is_digit;
    logic [3:0]       digit;
    logic [EXP_W-1:0] frac_exp;

    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;
    assign is_digit = (s_tdata >= CH_ZERO) && (s_tdata <= CH_NINE);
    assign digit    = 4'(s_tdata - CH_ZERO);
    assign frac_exp = EXP_W'(FP_W'(FRAC_DIGITS) - frac_pos_reg);

    always_comb
    begin
        negative_next       = negative_reg;
        pending_next        = pending_reg;
        frac_pos_next       = frac_pos_reg;
        push                = 1'b0;
        push_entry.op       = OP_EMIT;
        push_entry.addend   = '0;
        push_entry.negative = negative_reg;
        push_entry.line_end = 1'b0;
        if (accept)
        begin
            if (s_tuser[0])
            begin
                push                = 1'b1;
                push_entry.line_end = 1'b1;
                negative_next       = 1'b0;
                pending_next        = 1'b1;
                frac_pos_next       = '0;
            end
            else if (s_tdata == CH_MINUS)
            begin
                negative_next = 1'b1;
            end
            else if (s_tdata == CH_POINT)
            begin
                if (frac_pos_reg != FP_LIMIT)
                begin
                    frac_pos_next = frac_pos_reg + FP_W'(1);
                end
            end
            else if (is_digit)
            begin
                pending_next = 1'b1;
                if (frac_pos_reg != '0)
                begin
                    // past the last kept fraction digit: dropped
                    if (frac_pos_reg != FP_LIMIT)
                    begin
                        push              = 1'b1;
                        push_entry.op     = OP_FRAC_DIGIT;
                        push_entry.addend = ADDEND_TAB[frac_exp][digit];
                        frac_pos_next     = frac_pos_reg + FP_W'(1);
                    end
                end
                else
                begin
                    push              = 1'b1;
                    push_entry.op     = OP_INT_DIGIT;
                    push_entry.addend = ADDEND_TAB[EXP_INT][digit];
                end
            end
            else if (pending_reg)
            begin
                push          = 1'b1;
                negative_next = 1'b0;
                pending_next  = 1'b0;
                frac_pos_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            negative_reg <= 1'b0;
            pending_reg  <= 1'b1;
            frac_pos_reg <= '0;
        end
        else
        begin
            negative_reg <= negative_next;
            pending_reg  <= pending_next;
            frac_pos_reg <= frac_pos_next;
        end
    end

    assign status.negative = negative_reg;
    assign status.pending  = pending_reg;
    assign status.frac_pos = frac_pos_reg;

endmodule

/* hdl/dtnp_queue.sv */
module dtnp_queue
    import dtnp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  q_entry_t  push_entry,
    input  logic      pop,
    output q_entry_t  pop_entry,
    output q_status_t status
);

    q_entry_t          mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign pop_entry    = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == QCNT_W'(QDEPTH));
    assign status.empty = (count_reg == '0);

endmodule

/* hdl/dtnp_back.sv */
module dtnp_back
    import dtnp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  q_status_t        q_status,
    input  q_entry_t         pop_entry,
    output logic             pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [VAL_W-1:0] m_tdata,
    output logic             m_tlast,
    output logic [0:0]       m_tuser
);

    logic [MAG_W-1:0] mag_reg, mag_next;
    logic             sat_reg, sat_next;
    logic             out_valid_reg, out_valid_next;
    logic [VAL_W-1:0] out_data_reg, out_data_next;
    logic             out_last_reg, out_last_next;
    logic             out_ovf_reg, out_ovf_next;

    logic             out_free;
    logic [MAG_W+3:0] sum_int;
    logic [MAG_W:0]   sum_frac;
    logic [VAL_W-1:0] mag_ext;

    assign out_free = !out_valid_reg || m_tready;
    assign pop      = !q_status.empty && ((pop_entry.op != OP_EMIT) || out_free);
    assign mag_ext  = {1'b0, mag_reg};

    // 10*m + addend: exact, so clipping is a check of the top bits
    assign sum_int  = {1'b0, mag_reg, 3'b000} + {3'b000, mag_reg, 1'b0}
                    + {4'b0000, pop_entry.addend};
    assign sum_frac = {1'b0, mag_reg} + {1'b0, pop_entry.addend};

    always_comb
    begin
        mag_next       = mag_reg;
        sat_next       = sat_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;
        if (pop)
        begin
            unique case (pop_entry.op)
                OP_INT_DIGIT:
                begin
                    if (sum_int[MAG_W+3:MAG_W] != '0)
                    begin
                        mag_next = MAG_MAX;
                        sat_next = 1'b1;
                    end
                    else
                    begin
                        mag_next = sum_int[MAG_W-1:0];
                    end
                end
                OP_FRAC_DIGIT:
                begin
                    if (sum_frac[MAG_W])
                    begin
                        mag_next = MAG_MAX;
                        sat_next = 1'b1;
                    end
                    else
                    begin
                        mag_next = sum_frac[MAG_W-1:0];
                    end
                end
                OP_EMIT:
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = pop_entry.negative ? (~mag_ext + VAL_W'(1)) : mag_ext;
                    out_last_next  = pop_entry.line_end;
                    out_ovf_next   = sat_reg;
                    mag_next       = '0;
                    sat_next       = 1'b0;
                end
                default:
                begin
                    mag_next = mag_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_reg       <= '0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mag_reg       <= mag_next;
            sat_reg       <= sat_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_ovf_reg  <= out_ovf_next;
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tlast    = out_last_reg;
    assign m_tuser[0] = out_ovf_reg;

endmodule

/* hdl/decimal_text_number_parser.sv */
// channel | dir | tdata          | tuser          | tlast
// s_*     | in  | char_code[7:0] | kind[0]        | -
// m_*     | out | value_scaled   | overflow[0]    | line_end
//
// One character per cycle sustained while m_* accepts; a number is registered
// in the queue and the output register. Front decodes and looks up the digit
// addend, a two-entry queue feeds the back, whose 67-bit multiply-by-ten add
// sets the clock. Reset sets control state, not queue memory or output data. A
// stall on m_* fills the queue, then drops s_tready; digits pop, emits wait.
module decimal_text_number_parser
    import dtnp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // char_code
    input  logic [0:0]       s_tuser,   // kind
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [VAL_W-1:0] m_tdata,   // value_scaled
    output logic             m_tlast,
    output logic [0:0]       m_tuser    // overflow
);

    logic          q_push;
    logic          q_pop;
    q_entry_t      q_push_entry;
    q_entry_t      q_pop_entry;
    q_status_t     q_status;
    front_status_t f_status;

    dtnp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .q_status   (q_status),
        .push       (q_push),
        .push_entry (q_push_entry),
        .status     (f_status)
    );

    dtnp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_push_entry),
        .pop        (q_pop),
        .pop_entry  (q_pop_entry),
        .status     (q_status)
    );

    dtnp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_status   (q_status),
        .pop_entry  (q_pop_entry),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

    a_eol_resets_front: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser[0])
        |=> (f_status.pending && !f_status.negative && (f_status.frac_pos == '0)))
        else $error("front state not cleared after end of line");

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_status.empty)
        else $error("queue popped while empty");

    a_ovf_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> ((m_tdata == SAT_POS) || (m_tdata == SAT_NEG)))
        else $error("overflow flagged on unsaturated value");

    a_no_min_value: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata != VAL_MIN))
        else $error("value outside magnitude range");

endmodule

/* tb/decimal_text_number_parser_tb.sv */
`timescale 1ns / 100ps

module decimal_text_number_parser_tb;
    import dtnp_pkg::*;

    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_EOL  = 1'b1;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_HIGH  = 8'hFF;

    localparam int RANDOM_ITEMS = 750;

    typedef struct {
        logic [VAL_W-1:0] value;
        logic             line_end;
        logic             overflow;
    } parsed_number_t;

    class number_scoreboard;
        parsed_number_t   expected_numbers[$];
        logic [MAG_W-1:0] mag;
        bit               neg;
        int               frac_pos;
        bit               pending;
        bit               sat;
        int               errors;
        int               chars_seen;
        int               lines_seen;
        int               numbers_checked;
        int               negatives_seen;
        int               saturations_seen;

        function new();
            start_line();
        endfunction

        function void clear_value();
            mag      = '0;
            neg      = 1'b0;
            frac_pos = 0;
            sat      = 1'b0;
        endfunction

        function void start_line();
            clear_value();
            pending = 1'b1;
        endfunction

        function logic [63:0] ten_pow(int n);
            logic [63:0] r;
            r = 64'd1;
            for (int i = 0; i < n; i++)
                r = r * 64'd10;
            return r;
        endfunction

        function void add_clipped(logic [63:0] addend);
            logic [63:0] room;
            room = {1'b0, MAG_MAX} - {1'b0, mag};
            if (addend > room)
            begin
                mag = MAG_MAX;
                sat = 1'b1;
            end
            else
                mag = MAG_W'({1'b0, mag} + addend);
        endfunction

        function void push_number(bit last);
            parsed_number_t n;
            n.value    = neg ? (~{1'b0, mag} + VAL_W'(1)) : {1'b0, mag};
            n.line_end = last;
            n.overflow = sat;
            expected_numbers = {expected_numbers, n};
        endfunction

        function void take_char(logic kind, logic [7:0] code);
            logic [63:0] digit;
            chars_seen++;
            if (kind == KIND_EOL)
            begin
                lines_seen++;
                push_number(1'b1);
                start_line();
                return;
            end
            digit = 64'(code - CH_ZERO);
            if (code == CH_MINUS)
                neg = 1'b1;
            else if (code == CH_POINT)
            begin
                if (frac_pos < FRAC_DIGITS + 1)
                    frac_pos++;
            end
            else if (code >= CH_ZERO && code <= CH_NINE)
            begin
                pending = 1'b1;
                if (frac_pos != 0)
                begin
                    if (frac_pos <= FRAC_DIGITS)
                        add_clipped(digit * ten_pow(FRAC_DIGITS - frac_pos));
                    if (frac_pos < FRAC_DIGITS + 1)
                        frac_pos++;
                end
                else
                begin
                    if (mag > MAG_MAX / 10)
                    begin
                        mag = MAG_MAX;
                        sat = 1'b1;
                    end
                    else
                        mag = MAG_W'(mag * 10);
                    add_clipped(digit * ten_pow(FRAC_DIGITS));
                end
            end
            else if (pending)
            begin
                push_number(1'b0);
                clear_value();
                pending = 1'b0;
            end
        endfunction

        function void check_number(logic [VAL_W-1:0] value, logic last, logic ovf);
            parsed_number_t n;
            if (expected_numbers.size() == 0)
            begin
                $display("%0t: unexpected number: actual value %h line_end %b overflow %b",
                         $time, value, last, ovf);
                errors++;
                return;
            end
            n = expected_numbers.pop_front();
            numbers_checked++;
            if (value[VAL_W-1])
                negatives_seen++;
            if (ovf)
                saturations_seen++;
            if (value !== n.value)
            begin
                $display("%0t: value_scaled mismatch: expected %h, actual %h",
                         $time, n.value, value);
                errors++;
            end
            if (last !== n.line_end)
            begin
                $display("%0t: line_end mismatch: expected %b, actual %b",
                         $time, n.line_end, last);
                errors++;
            end
            if (ovf !== n.overflow)
            begin
                $display("%0t: overflow mismatch: expected %b, actual %b",
                         $time, n.overflow, ovf);
                errors++;
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [7:0]       s_tdata;
    logic [0:0]       s_tuser;
    logic             m_tvalid;
    logic             m_tready;
    logic [VAL_W-1:0] m_tdata;
    logic             m_tlast;
    logic [0:0]       m_tuser;

    number_scoreboard sb = new();
    int               items_sent;
    int               burst_left;

    decimal_text_number_parser u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial
        clk = 1'b0;
    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            sb.take_char(s_tuser[0], s_tdata);
        if (rst_n && m_tvalid && m_tready)
            sb.check_number(m_tdata, m_tlast, m_tuser[0]);
    end

    task automatic push_char(input logic kind, input logic [7:0] code);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 2);
            if (gap > 0)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= code;
        do
            @(posedge clk);
        while (!s_tready);
        burst_left--;
        items_sent++;
    endtask

    function automatic logic [7:0] other_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while ((c >= CH_ZERO && c <= CH_NINE) || c == CH_MINUS || c == CH_POINT);
        return c;
    endfunction

    function automatic logic [7:0] random_digit();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    task automatic send_separator();
        case ($urandom_range(0, 3))
            0: push_char(KIND_CHAR, CH_COMMA);
            1: push_char(KIND_CHAR, CH_SPACE);
            default: push_char(KIND_CHAR, other_char());
        endcase
    endtask

    // well-formed line with random content
    task automatic send_line();
        int nums;
        int n_int;
        int n_frac;
        int n_pts;
        int sign_at;
        nums = $urandom_range(1, 5);
        for (int i = 0; i < nums; i++)
        begin
            n_int   = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 20)
                                                   : $urandom_range(0, 4);
            n_frac  = $urandom_range(0, 9);
            n_pts   = ($urandom_range(0, 3) == 0) ? 0 : (($urandom_range(0, 4) == 0) ? 2 : 1);
            sign_at = ($urandom_range(0, 2) == 0) ? $urandom_range(0, n_int) : -1;
            for (int j = 0; j <= n_int; j++)
            begin
                if (j == sign_at)
                    push_char(KIND_CHAR, CH_MINUS);
                if (j < n_int)
                    push_char(KIND_CHAR, random_digit());
            end
            for (int j = 0; j < n_pts; j++)
                push_char(KIND_CHAR, CH_POINT);
            for (int j = 0; j < n_frac; j++)
                push_char(KIND_CHAR, random_digit());
            if (i < nums - 1 || $urandom_range(0, 1))
                repeat ($urandom_range(1, 3)) send_separator();
        end
        push_char(KIND_EOL, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 12))
            push_char(($urandom_range(0, 11) == 0) ? KIND_EOL : KIND_CHAR,
                      8'($urandom_range(0, 255)));
        push_char(KIND_EOL, 8'($urandom_range(0, 255)));
    endtask

    // receiver: changing stall modes plus two long hold-offs
    initial
    begin : receiver
        int rx_cycle;
        int hold_left;
        int mode;
        int mode_left;
        rx_cycle  = 0;
        hold_left = 0;
        mode      = 0;
        mode_left = 0;
        m_tready  = 1'b0;
        forever
        begin
            @(negedge clk);
            rx_cycle++;
            if (rx_cycle == 500 || rx_cycle == 1400)
                hold_left = 250;
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= rx_cycle[1];
                endcase
        end
    end

    initial
    begin
        #400000;
        $display("timeout: %0d numbers still expected", sb.expected_numbers.size());
        $display("decimal_text_number_parser_tb: FAIL");
        $finish;
    end

    initial
    begin
        int target;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        items_sent = 0;
        burst_left = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // leading separator emits zero; sign and points carry past a merged separator
        push_char(KIND_CHAR, CH_COMMA);
        push_char(KIND_CHAR, CH_MINUS);
        push_char(KIND_CHAR, CH_COMMA);
        push_char(KIND_CHAR, CH_POINT);
        push_char(KIND_CHAR, CH_POINT);
        push_char(KIND_CHAR, CH_ZERO + 8'd5);
        push_char(KIND_CHAR, CH_COLON);
        // saturation
        repeat (14) push_char(KIND_CHAR, CH_NINE);
        push_char(KIND_CHAR, CH_HIGH);
        push_char(KIND_CHAR, CH_SLASH);
        push_char(KIND_CHAR, CH_ZERO);
        push_char(KIND_EOL, 8'h00);
        push_char(KIND_EOL, CH_HIGH);

        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target)
        begin
            if ($urandom_range(0, 7) == 0)
                send_noise();
            else
                send_line();
        end
        @(negedge clk);
        s_tvalid <= 1'b0;

        while (sb.expected_numbers.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        $display("run covered %0d characters over %0d lines; %0d numbers checked",
                 sb.chars_seen, sb.lines_seen, sb.numbers_checked);
        $display("of which %0d negative and %0d saturated; %0d errors",
                 sb.negatives_seen, sb.saturations_seen, sb.errors);
        if (sb.errors == 0)
            $display("decimal_text_number_parser_tb: PASS");
        else
            $display("decimal_text_number_parser_tb: FAIL");
        $finish;
    end

endmodule
